FILE: rtl/cdc_pkg.sv
// Shared types, constants and calendar helper functions for the calendar date counter.
package cdc_pkg;

	localparam logic [1:0] OP_ADVANCE = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_COMPARE = 2'd2;

	localparam logic [1:0] ORD_EARLIER = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_LATER   = 2'd2;

	localparam logic [13:0] MAX_YEAR   = 14'd9999;
	localparam logic [13:0] RESET_YEAR = 14'd2001;
	localparam logic [2:0]  LAST_WDAY  = 3'd6;
	// 2001-01-01 is a Monday; 2001 mod 4, mod 16 and mod 25 are all 1.
	localparam logic [2:0]  RESET_WDAY = 3'd1;
	localparam logic [1:0]  RESET_R4   = 2'd1;
	localparam logic [3:0]  RESET_R16  = 4'd1;
	localparam logic [4:0]  RESET_R25  = 5'd1;
	localparam logic [4:0]  LAST_R25   = 5'd24;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  in_day;
		logic [3:0]  in_month;
		logic [13:0] in_year;
	} cdc_in_t;

	typedef struct packed {
		logic [4:0]  cur_day;
		logic [3:0]  cur_month;
		logic [13:0] cur_year;
		logic [2:0]  weekday;
		logic        leap_flag;
		logic        error_flag;
		logic [1:0]  order;
	} cdc_out_t;

	// Floor of x / 25 for any 14-bit x, by reciprocal multiplication.
	function automatic logic [9:0] div25(input logic [13:0] x);
		logic [26:0] p;
		begin
			p = 27'(x) * 27'd5243;
			return p[26:17];
		end
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
			4'd2: return leap ? 5'd29 : 5'd28;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [2:0] month_offset(input logic [3:0] m);
		case (m)
			4'd2: return 3'd3;
			4'd3: return 3'd2;
			4'd4: return 3'd5;
			4'd6: return 3'd3;
			4'd7: return 3'd5;
			4'd8: return 3'd1;
			4'd9: return 3'd4;
			4'd10: return 3'd6;
			4'd11: return 3'd2;
			4'd12: return 3'd4;
			default: return 3'd0;
		endcase
	endfunction

	// Since 8 is 1 mod 7, folding octal digits keeps the residue.
	function automatic logic [2:0] mod7(input logic [14:0] x);
		logic [5:0] s;
		logic [3:0] t;
		begin
			s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
			t = 4'(s[2:0]) + 4'(s[5:3]);
			return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
		end
	endfunction

	function automatic logic leap_of(input logic [1:0] r4, input logic [3:0] r16,
			input logic [4:0] r25);
		return (r4 == 2'd0) && ((r25 != 5'd0) || (r16 == 4'd0));
	endfunction

endpackage

FILE: rtl/calendar_date_counter.sv
// Gregorian date counter with weekday and leap flag, three pipeline stages and a result register.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  input   | in_valid / in_ready     | in_item  (opcode, in_day, in_month, in_year)
//  output  | out_valid / out_ready   | out_item (date, weekday, leap, error, order)
//
// One item per cycle while the output is not stalled; each passes stages one to three, then the result register.
// Stages one to three register the operand and work out its divisions by 25 and its weekday;
// the date itself is updated in the cycle that writes the result register.
// The result register holds the stored date, so after reset it reads 2001-01-01, a Monday.
// A stalled output holds the result; stages ahead of it fill their empty slots and then stop.
module calendar_date_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cdc_pkg::cdc_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output cdc_pkg::cdc_out_t out_item
);
	import cdc_pkg::*;

	logic     v_s1, v_s2, v_s3, out_valid_q;
	logic     rdy1, rdy2, rdy3, rdy_out;
	cdc_in_t  in_s1, in_s2, in_s3;
	logic [13:0] yy_s2;
	logic [9:0]  qy_s2;
	logic [7:0]  qc_s2;
	logic [5:0]  qq_s2;
	logic        ok_s3;
	logic [2:0]  wd_s3;
	logic [4:0]  r25_s3;
	cdc_out_t    out_q;
	logic [1:0]  r4_q;
	logic [3:0]  r16_q;
	logic [4:0]  r25_q;

	// Stage 2 combinational
	logic [13:0] yy_c;
	logic [9:0]  qc_full, qq_full;
	// Stage 3 combinational
	logic [13:0] rem_c;
	logic [4:0]  r25_c;
	logic        leap_in_c, ok_c;
	logic [14:0] sum_c;
	// Commit
	cdc_out_t    nxt;
	logic [1:0]  n4;
	logic [3:0]  n16;
	logic [4:0]  n25, ml;

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy3    = !v_s3 || rdy_out;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	always_comb begin
		yy_c    = (in_s1.in_month < 4'd3) ? in_s1.in_year - 14'd1 : in_s1.in_year;
		qc_full = div25({2'b00, yy_c[13:2]});
		qq_full = div25({4'b0000, yy_c[13:4]});
	end

	always_ff @(posedge clk) begin
		if (rdy1) in_s1 <= in_item;
		if (rdy2) begin
			in_s2 <= in_s1;
			yy_s2 <= yy_c;
			qy_s2 <= div25(in_s1.in_year);
			qc_s2 <= qc_full[7:0];
			qq_s2 <= qq_full[5:0];
		end
	end

	always_comb begin
		rem_c = in_s2.in_year - (({4'b0, qy_s2} << 4) + ({4'b0, qy_s2} << 3) + {4'b0, qy_s2});
		r25_c = rem_c[4:0];
		leap_in_c = leap_of(in_s2.in_year[1:0], in_s2.in_year[3:0], r25_c);
		ok_c = (in_s2.in_day != 5'd0) && (in_s2.in_year != 14'd0)
			&& (in_s2.in_year <= MAX_YEAR)
			&& (in_s2.in_day <= month_len(in_s2.in_month, leap_in_c));
		sum_c = 15'(yy_s2) + 15'(yy_s2[13:2]) - 15'(qc_s2) + 15'(qq_s2)
			+ 15'(month_offset(in_s2.in_month)) + 15'(in_s2.in_day);
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			in_s3  <= in_s2;
			ok_s3  <= ok_c;
			wd_s3  <= mod7(sum_c);
			r25_s3 <= r25_c;
		end
	end

	always_comb begin
		nxt = out_q;
		nxt.error_flag = 1'b0;
		nxt.order = ORD_EARLIER;
		n4  = r4_q;
		n16 = r16_q;
		n25 = r25_q;
		ml  = month_len(out_q.cur_month, out_q.leap_flag);
		case (in_s3.opcode)
			OP_ADVANCE: begin
				if (out_q.cur_day < ml) begin
					nxt.cur_day = out_q.cur_day + 5'd1;
				end else if (out_q.cur_month < 4'd12) begin
					nxt.cur_day = 5'd1;
					nxt.cur_month = out_q.cur_month + 4'd1;
				end else if (out_q.cur_year < MAX_YEAR) begin
					nxt.cur_day = 5'd1;
					nxt.cur_month = 4'd1;
					nxt.cur_year = out_q.cur_year + 14'd1;
					n4  = r4_q + 2'd1;
					n16 = r16_q + 4'd1;
					n25 = (r25_q == LAST_R25) ? 5'd0 : r25_q + 5'd1;
				end else begin
					nxt.error_flag = 1'b1;
				end
				if (!nxt.error_flag) begin
					nxt.weekday = (out_q.weekday == LAST_WDAY) ? 3'd0 : out_q.weekday + 3'd1;
				end
			end
			OP_SET: begin
				if (ok_s3) begin
					nxt.cur_day = in_s3.in_day;
					nxt.cur_month = in_s3.in_month;
					nxt.cur_year = in_s3.in_year;
					nxt.weekday = wd_s3;
					n4  = in_s3.in_year[1:0];
					n16 = in_s3.in_year[3:0];
					n25 = r25_s3;
				end else begin
					nxt.error_flag = 1'b1;
				end
			end
			OP_COMPARE: begin
				if ({out_q.cur_year, out_q.cur_month, out_q.cur_day}
						< {in_s3.in_year, in_s3.in_month, in_s3.in_day}) begin
					nxt.order = ORD_EARLIER;
				end else if ({out_q.cur_year, out_q.cur_month, out_q.cur_day}
						== {in_s3.in_year, in_s3.in_month, in_s3.in_day}) begin
					nxt.order = ORD_EQUAL;
				end else begin
					nxt.order = ORD_LATER;
				end
			end
			default: ;
		endcase
		nxt.leap_flag = leap_of(n4, n16, n25);
	end

	// The result register doubles as the stored date.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q.cur_day    <= 5'd1;
			out_q.cur_month  <= 4'd1;
			out_q.cur_year   <= RESET_YEAR;
			out_q.weekday    <= RESET_WDAY;
			out_q.leap_flag  <= 1'b0;
			out_q.error_flag <= 1'b0;
			out_q.order      <= ORD_EARLIER;
			r4_q  <= RESET_R4;
			r16_q <= RESET_R16;
			r25_q <= RESET_R25;
		end else if (v_s3 && rdy_out) begin
			out_q <= nxt;
			r4_q  <= n4;
			r16_q <= n16;
			r25_q <= n25;
		end
	end

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_q.cur_month >= 4'd1) && (out_q.cur_month <= 4'd12) && (out_q.cur_day != 5'd0)
		&& (out_q.cur_year != 14'd0) && (out_q.cur_year <= MAX_YEAR))
		else $error("stored date left the valid range");

	a_year_residues: assert property (@(posedge clk) disable iff (!arst_n)
		(r4_q == out_q.cur_year[1:0]) && (r16_q == out_q.cur_year[3:0]) && (r25_q < 5'd25))
		else $error("year residue counters out of step with the stored year");

	a_err_no_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.error_flag && (out_q.order != ORD_EARLIER)))
		else $error("result carries both an error and an order");

	a_error_holds_date: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy_out && nxt.error_flag) |=> $stable(out_q.cur_year)
		&& $stable(out_q.cur_month) && $stable(out_q.cur_day))
		else $error("failed step changed the stored date");

endmodule

FILE: verif/tb_calendar_date_counter.sv
// Self-checking testbench for the calendar date counter: directed and random items, checked in order.
`timescale 1ns / 1ps

module tb_calendar_date_counter;
	import cdc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 166;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 30;

	// Sakamoto month shifts, indexed by month minus one (December in the top slot).
	localparam logic [11:0][2:0] MONTH_SHIFT = {3'd4, 3'd2, 3'd6, 3'd4, 3'd1, 3'd5,
		3'd3, 3'd0, 3'd5, 3'd2, 3'd3, 3'd0};

	typedef struct packed {
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
	} date_t;

	localparam date_t RESET_DATE = {RESET_YEAR, 4'd1, 5'd1};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	cdc_in_t  in_item = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	cdc_out_t out_item;

	cdc_in_t  request_queue[$];
	cdc_out_t predicted_results[$];
	date_t    model_date = RESET_DATE;
	date_t    plan_date = RESET_DATE;
	int       sender_idle_pct = 0;
	int       receiver_stall_pct = 0;
	int       phase_items = 0;
	int       mismatches = 0;
	int       results_checked = 0;
	int       error_results = 0;
	int       op_count [0:3];

	calendar_date_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic is_leap_year(input logic [13:0] y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [13:0] y);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
			4'd2: return is_leap_year(y) ? 5'd29 : 5'd28;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [2:0] weekday_of(input date_t dt);
		int unsigned yy;
		yy = (dt.m < 4'd3) ? int'(dt.y) - 1 : int'(dt.y);
		return 3'((yy + yy / 4 - yy / 100 + yy / 400 + MONTH_SHIFT[dt.m - 4'd1] + dt.d) % 7);
	endfunction

	// One calendar step: returns the result of the item and the date it leaves behind.
	function automatic cdc_out_t calendar_step(input date_t cur, input cdc_in_t it,
			output date_t nxt);
		cdc_out_t res;
		date_t    operand;
		res = '0;
		nxt = cur;
		operand = {it.in_year, it.in_month, it.in_day};
		case (it.opcode)
			OP_ADVANCE: begin
				if (cur.d < days_in_month(cur.m, cur.y)) begin
					nxt.d = cur.d + 5'd1;
				end else if (cur.m < 4'd12) begin
					nxt.d = 5'd1;
					nxt.m = cur.m + 4'd1;
				end else if (cur.y < MAX_YEAR) begin
					nxt = {cur.y + 14'd1, 4'd1, 5'd1};
				end else begin
					res.error_flag = 1'b1;
				end
			end
			OP_SET: begin
				if (operand.d != 0 && operand.y != 0 && operand.y <= MAX_YEAR &&
						operand.d <= days_in_month(operand.m, operand.y)) begin
					nxt = operand;
				end else begin
					res.error_flag = 1'b1;
				end
			end
			OP_COMPARE: begin
				// The packed layout orders year, month, day as one raw number.
				if (cur < operand) res.order = ORD_EARLIER;
				else if (cur == operand) res.order = ORD_EQUAL;
				else res.order = ORD_LATER;
			end
			default: ;
		endcase
		res.cur_day = nxt.d;
		res.cur_month = nxt.m;
		res.cur_year = nxt.y;
		res.weekday = weekday_of(nxt);
		res.leap_flag = is_leap_year(nxt.y);
		return res;
	endfunction

	// Queue an item and track the date it will leave, so later items can aim near it.
	task automatic add_item(input logic [1:0] op, input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y);
		cdc_in_t  it;
		it = {op, d, m, y};
		request_queue.push_back(it);
		void'(calendar_step(plan_date, it, plan_date));
		if (op != OP_UNUSED) phase_items++;
	endtask

	task automatic add_advances(input int n);
		repeat (n) add_item(OP_ADVANCE, 5'($urandom), 4'($urandom), 14'($urandom));
	endtask

	task automatic add_random_item();
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		int          pick;
		pick = $urandom_range(99);
		d = 5'($urandom_range(1, 28));
		m = 4'($urandom_range(1, 12));
		y = 14'($urandom_range(1, MAX_YEAR));
		if (pick < 40) begin
			add_advances($urandom_range(1, 40));
		end else if (pick < 60) begin
			// Valid dates, weighted toward the first and last years, century years, multiples of four and month ends.
			case ($urandom_range(5))
				0: y = 14'd1;
				1: y = MAX_YEAR;
				2: y = 14'(100 * $urandom_range(1, 99));
				3: y = 14'(4 * $urandom_range(1, 2499));
				default: ;
			endcase
			case ($urandom_range(2))
				0: d = days_in_month(m, y);
				1: d = days_in_month(m, y) - 5'd1;
				default: d = 5'($urandom_range(1, days_in_month(m, y)));
			endcase
			add_item(OP_SET, d, m, y);
		end else if (pick < 65) begin
			add_item(OP_SET, 5'($urandom_range(20, 31)), 4'd12, MAX_YEAR);
			add_advances($urandom_range(1, 15));
		end else if (pick < 75) begin
			case ($urandom_range(3))
				0: d = 5'd0;
				1: m = $urandom_range(1) ? 4'd0 : 4'($urandom_range(13, 15));
				2: y = $urandom_range(1) ? 14'd0 : 14'($urandom_range(MAX_YEAR + 1, 16383));
				default: begin
					m = 4'd2;
					d = 5'($urandom_range(days_in_month(m, y) + 1, 31));
				end
			endcase
			add_item(OP_SET, d, m, y);
		end else if (pick < 93) begin
			{y, m, d} = plan_date;
			case ($urandom_range(4))
				0: ;
				1: d = 5'(d + $urandom_range(2) - 1);
				2: m = 4'(m + $urandom_range(2) - 1);
				3: y = 14'(y + $urandom_range(2) - 1);
				default: {y, m, d} = 23'($urandom);
			endcase
			add_item(OP_COMPARE, d, m, y);
		end else if (pick < 95) begin
			add_item(OP_UNUSED, 5'($urandom), 4'($urandom), 14'($urandom));
		end else begin
			add_item(2'($urandom), 5'($urandom), 4'($urandom), 14'($urandom));
		end
	endtask

	task automatic report_field(input string name, input logic [13:0] want,
			input logic [13:0] got);
		if (want !== got)
			$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
	endtask

	task automatic check_result(input cdc_out_t want, input cdc_out_t got);
		results_checked++;
		if (got.error_flag === 1'b1) error_results++;
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				report_field("cur_day", want.cur_day, got.cur_day);
				report_field("cur_month", want.cur_month, got.cur_month);
				report_field("cur_year", want.cur_year, got.cur_year);
				report_field("weekday", want.weekday, got.weekday);
				report_field("leap_flag", want.leap_flag, got.leap_flag);
				report_field("error_flag", want.error_flag, got.error_flag);
				report_field("order", want.order, got.order);
			end
		end
	endtask

	// Driver: predicts each item as it is accepted, then offers the next one or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			model_date <= RESET_DATE;
			foreach (op_count[i]) op_count[i] <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_results.push_back(calendar_step(model_date, in_item, model_date));
				op_count[in_item.opcode] <= op_count[in_item.opcode] + 1;
			end
			if (!in_valid || in_ready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_item <= request_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t ns: no result expected, actual %p", $time, out_item);
				end else begin
					check_result(predicted_results.pop_front(), out_item);
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin
		int phase;
		// Reset date is a Monday; then leap days by the 400 and 100 rules.
		add_item(OP_COMPARE, 5'd1, 4'd1, RESET_YEAR);
		add_item(OP_ADVANCE, 5'd0, 4'd0, 14'd0);
		add_item(OP_SET, 5'd28, 4'd2, 14'd2000);
		add_item(OP_ADVANCE, 5'd0, 4'd0, 14'd0);
		add_item(OP_ADVANCE, 5'd0, 4'd0, 14'd0);
		add_item(OP_SET, 5'd28, 4'd2, 14'd1900);
		add_item(OP_ADVANCE, 5'd0, 4'd0, 14'd0);
		add_item(OP_SET, 5'd29, 4'd2, 14'd1900);
		add_item(OP_SET, 5'd29, 4'd2, 14'd2004);
		add_item(OP_SET, 5'd31, 4'd12, 14'd2023);
		add_item(OP_ADVANCE, 5'd0, 4'd0, 14'd0);
		// The last date holds and flags an error on advance.
		add_item(OP_SET, 5'd31, 4'd12, MAX_YEAR);
		add_item(OP_ADVANCE, 5'd0, 4'd0, 14'd0);
		add_item(OP_COMPARE, 5'd31, 4'd15, 14'h3fff);
		add_item(OP_COMPARE, 5'd0, 4'd0, 14'd0);
		add_item(OP_COMPARE, 5'd31, 4'd12, MAX_YEAR);
		add_item(OP_SET, 5'd1, 4'd1, 14'd1);
		add_item(OP_SET, 5'd0, 4'd5, 14'd2020);
		add_item(OP_SET, 5'd10, 4'd0, 14'd2020);
		add_item(OP_SET, 5'd10, 4'd13, 14'd2020);
		add_item(OP_SET, 5'd10, 4'd5, 14'd0);
		add_item(OP_SET, 5'd10, 4'd5, 14'd10000);
		add_item(OP_SET, 5'd31, 4'd4, 14'd2021);
		add_item(OP_UNUSED, 5'd31, 4'd15, 14'h3fff);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
				default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
			endcase
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) add_random_item();
			while (request_queue.size() != 0) @(posedge clk);
		end

		while (in_valid || predicted_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d advances, %0d sets, %0d compares, %0d unused opcodes.",
			results_checked, op_count[OP_ADVANCE], op_count[OP_SET], op_count[OP_COMPARE],
			op_count[OP_UNUSED]);
		$display("%0d results carried the error flag; %0d mismatching results.",
			error_results, mismatches);
		if (mismatches == 0) begin
			$display("tb_calendar_date_counter passed");
		end else begin
			$display("tb_calendar_date_counter failed");
		end
		$finish;
	end

	// Far beyond the slowest legal run, even with both sides idling most cycles.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still outstanding.", predicted_results.size());
		$display("tb_calendar_date_counter failed");
		$finish;
	end

endmodule
